// ===== rtl/filtered_event_counter_bank_top_assert.svh =====
// Assertion macros used by the counter bank's top level.
`ifndef FILTERED_EVENT_COUNTER_BANK_TOP_ASSERT_SVH
`define FILTERED_EVENT_COUNTER_BANK_TOP_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define FECB_ASSERT(lbl, cond, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define FECB_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fecb_pkg.sv =====
// Types and constants shared by the event counter bank modules.
package fecb_pkg;

   localparam int IDX_BITS = 5;

   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_EVENT = 2'd2;

   localparam logic [3:0] SEL_NONE    = 4'd0;
   localparam logic [3:0] SEL_CTR     = 4'd1;
   localparam logic [3:0] SEL_TYPE    = 4'd2;
   localparam logic [3:0] SEL_FILT    = 4'd3;
   localparam logic [3:0] SEL_CEN_SET = 4'd4;
   localparam logic [3:0] SEL_CEN_CLR = 4'd5;
   localparam logic [3:0] SEL_IEN_SET = 4'd6;
   localparam logic [3:0] SEL_IEN_CLR = 4'd7;
   localparam logic [3:0] SEL_OVF     = 4'd8;
   localparam logic [3:0] SEL_CFG     = 4'd9;
   localparam logic [3:0] SEL_GEN     = 4'd10;

   localparam logic [1:0] PART_FULL = 2'd0;
   localparam logic [1:0] PART_LOW  = 2'd1;
   localparam logic [1:0] PART_HIGH = 2'd2;

   localparam logic [1:0] FILT_CORE = 2'd0;
   localparam logic [1:0] FILT_INTID = 2'd1;
   localparam logic [1:0] FILT_CHIP = 2'd2;
   localparam logic [1:0] FILT_ANY = 2'd3;

   localparam logic [11:0] ADDR_TYPE_BASE = 12'h400;
   localparam logic [11:0] ADDR_FILT_BASE = 12'hA00;
   localparam logic [11:0] ADDR_CEN_SET   = 12'hC00;
   localparam logic [11:0] ADDR_CEN_CLR   = 12'hC20;
   localparam logic [11:0] ADDR_IEN_SET   = 12'hC40;
   localparam logic [11:0] ADDR_IEN_CLR   = 12'hC60;
   localparam logic [11:0] ADDR_OVF       = 12'hC80;
   localparam logic [11:0] ADDR_CFG       = 12'hE00;
   localparam logic [11:0] ADDR_GEN       = 12'hE04;

   localparam logic [31:0] FILTER_RESET = 32'hC000_0000;

   typedef struct packed {
      logic [3:0]          sel;
      logic [IDX_BITS-1:0] idx;
      logic [1:0]          part;
   } fecb_dec_type;

   typedef struct packed {
      logic       ctr_we;
      logic [1:0] part;
      logic       type_we;
      logic       filt_we;
   } fecb_lane_wr_type;

endpackage

// ===== rtl/fecb_decode.sv =====
// Register map address decoder of the event counter bank.
module fecb_decode #(
   parameter int CTR_COUNT = 32,
   parameter int COUNTER_BITS = 64
) (
   input  logic [11:0]             addr,
   input  logic                    wide,
   output fecb_pkg::fecb_dec_type  dec
);
   import fecb_pkg::*;

   localparam int SHIFT = (COUNTER_BITS > 32) ? 3 : 2;
   localparam logic [11:0] CTR_LIMIT = 12'(CTR_COUNT << SHIFT);
   localparam logic [11:0] PER_LIMIT = 12'(4 * CTR_COUNT);

   logic [11:0] type_off;
   logic [11:0] filt_off;

   always_comb begin
      type_off = addr - ADDR_TYPE_BASE;
      filt_off = addr - ADDR_FILT_BASE;
      dec.sel = SEL_NONE;
      dec.idx = '0;
      dec.part = PART_FULL;
      if (addr[1:0] == 2'b00) begin
         if (addr < CTR_LIMIT) begin
            dec.idx = IDX_BITS'(addr >> SHIFT);
            if (SHIFT == 3) begin
               if (wide) begin
                  dec.sel = addr[2] ? SEL_NONE : SEL_CTR;
                  dec.part = PART_FULL;
               end else begin
                  dec.sel = SEL_CTR;
                  dec.part = addr[2] ? PART_HIGH : PART_LOW;
               end
            end else begin
               dec.sel = SEL_CTR;
            end
         end else if (addr >= ADDR_TYPE_BASE && type_off < PER_LIMIT) begin
            dec.sel = SEL_TYPE;
            dec.idx = type_off[IDX_BITS+1:2];
         end else if (addr >= ADDR_FILT_BASE && filt_off < PER_LIMIT) begin
            dec.sel = SEL_FILT;
            dec.idx = filt_off[IDX_BITS+1:2];
         end else begin
            case (addr)
               ADDR_CEN_SET: dec.sel = SEL_CEN_SET;
               ADDR_CEN_CLR: dec.sel = SEL_CEN_CLR;
               ADDR_IEN_SET: dec.sel = SEL_IEN_SET;
               ADDR_IEN_CLR: dec.sel = SEL_IEN_CLR;
               ADDR_OVF:     dec.sel = SEL_OVF;
               ADDR_CFG:     dec.sel = SEL_CFG;
               ADDR_GEN:     dec.sel = SEL_GEN;
               default:      dec.sel = SEL_NONE;
            endcase
         end
      end
   end

endmodule

// ===== rtl/fecb_lane.sv =====
// One counter lane: counter, event type, filter word and match logic.
module fecb_lane #(
   parameter int COUNTER_BITS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fecb_pkg::fecb_lane_wr_type  wr,
   input  logic [63:0]                 wdata,
   input  logic                        cnt_en,
   input  logic [7:0]                  event_code,
   input  logic [15:0]                 core_id,
   input  logic [15:0]                 intid,
   input  logic [15:0]                 chip_id,
   output logic [63:0]                 ctr_value,
   output logic [31:0]                 type_value,
   output logic [31:0]                 filt_value,
   output logic                        wrap
);
   import fecb_pkg::*;

   logic [COUNTER_BITS-1:0] ctr_ff;
   logic [COUNTER_BITS-1:0] ctr_in;
   logic [31:0]             type_ff;
   logic [31:0]             type_in;
   logic [31:0]             filt_ff;
   logic [31:0]             filt_in;
   logic [63:0]             cur64;
   logic [63:0]             new64;
   logic [15:0]             fval;
   logic [15:0]             attr;
   logic [15:0]             ign;
   logic                    pass;
   logic                    inc;

   always_comb begin
      fval = filt_ff[15:0];
      case (filt_ff[31:30])
         FILT_CORE:  attr = core_id;
         FILT_INTID: attr = intid;
         default:    attr = chip_id;
      endcase
      ign = fval ^ (fval + 16'd1);
      if (filt_ff[31:30] == FILT_ANY) begin
         pass = 1'b1;
      end else if (filt_ff[29]) begin
         pass = (attr == fval);
      end else begin
         pass = ((attr & ~ign) == (fval & ~ign));
      end
      inc = cnt_en && pass && (type_ff == {24'd0, event_code});
      wrap = inc && (&ctr_ff);

      cur64 = 64'(ctr_ff);
      case (wr.part)
         PART_LOW:  new64 = {cur64[63:32], wdata[31:0]};
         PART_HIGH: new64 = {wdata[31:0], cur64[31:0]};
         default:   new64 = wdata;
      endcase

      ctr_in = ctr_ff;
      if (wr.ctr_we) begin
         ctr_in = new64[COUNTER_BITS-1:0];
      end else if (inc) begin
         ctr_in = ctr_ff + COUNTER_BITS'(1);
      end
      type_in = wr.type_we ? wdata[31:0] : type_ff;
      filt_in = wr.filt_we ? wdata[31:0] : filt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff <= '0;
         type_ff <= '0;
         filt_ff <= FILTER_RESET;
      end else begin
         ctr_ff <= ctr_in;
         type_ff <= type_in;
         filt_ff <= filt_in;
      end
   end

   assign ctr_value = cur64;
   assign type_value = type_ff;
   assign filt_value = filt_ff;

endmodule

// ===== rtl/filtered_event_counter_bank_top.sv =====
// Top level of the filtered event counter bank with its control registers.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   func, addr, wdata, wide, event_code,
//                                              core_id, intid, chip_id
//   rsp      out        rsp_valid/rsp_stall   rdata, irq
//
// An item is captured in an input register and completes when its result is loaded
// into the output register, so one item is accepted per cycle while req_stall is low.
// Reset is synchronous and returns every counter, type, filter and mask to its reset value.
// A stalled output register holds its item and stalls the input once the input
// register is also occupied.
module filtered_event_counter_bank_top #(
   parameter int CTR_COUNT = 32,
   parameter int COUNTER_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [11:0] req_addr,
   input  logic [63:0] req_wdata,
   input  logic        req_wide,
   input  logic [7:0]  req_event_code,
   input  logic [15:0] req_core_id,
   input  logic [15:0] req_intid,
   input  logic [15:0] req_chip_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_rdata,
   output logic        rsp_irq
);
   import fecb_pkg::*;
   `include "filtered_event_counter_bank_top_assert.svh"

   localparam logic [5:0] NC_M1 = 6'(CTR_COUNT - 1);
   localparam logic [5:0] CB_M1 = 6'(COUNTER_BITS - 1);
   localparam logic [63:0] CFG_WORD = {48'd0, 2'd0, CB_M1, 2'd0, NC_M1};

   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   logic [1:0]              s1_func_ff;
   logic [11:0]             s1_addr_ff;
   logic [63:0]             s1_wdata_ff;
   logic                    s1_wide_ff;
   logic [7:0]              s1_code_ff;
   logic [15:0]             s1_core_ff;
   logic [15:0]             s1_intid_ff;
   logic [15:0]             s1_chip_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [63:0]             rsp_rdata_ff;
   logic [63:0]             rsp_rdata_in;
   logic                    rsp_irq_ff;
   logic                    rsp_irq_in;

   logic [CTR_COUNT-1:0]    cen_ff;
   logic [CTR_COUNT-1:0]    cen_in;
   logic [CTR_COUNT-1:0]    ien_ff;
   logic [CTR_COUNT-1:0]    ien_in;
   logic [CTR_COUNT-1:0]    ovf_ff;
   logic [CTR_COUNT-1:0]    ovf_in;
   logic                    gen_ff;
   logic                    gen_in;

   logic                    out_free;
   logic                    accept;
   logic                    fire;
   logic                    do_write;
   logic                    do_event;
   fecb_dec_type            dec;
   logic [CTR_COUNT-1:0]    wn;
   logic [CTR_COUNT-1:0]    wrap_vec;
   fecb_lane_wr_type        lane_wr [CTR_COUNT];
   logic [63:0]             lane_ctr [CTR_COUNT];
   logic [31:0]             lane_type [CTR_COUNT];
   logic [31:0]             lane_filt [CTR_COUNT];
   logic [63:0]             ctr_sel;
   logic [31:0]             type_sel;
   logic [31:0]             filt_sel;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept = req_valid && !req_stall;
   assign fire = s1_valid_ff && out_free;
   assign do_write = fire && (s1_func_ff == FUNC_WRITE);
   assign do_event = fire && (s1_func_ff == FUNC_EVENT) && gen_ff;
   assign wn = s1_wdata_ff[CTR_COUNT-1:0];

   fecb_decode #(
      .CTR_COUNT    (CTR_COUNT),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_decode (
      .addr (s1_addr_ff),
      .wide (s1_wide_ff),
      .dec  (dec)
   );

   for (genvar i = 0; i < CTR_COUNT; i++) begin : g_lane
      logic hit;

      assign hit = (dec.idx == IDX_BITS'(i));
      assign lane_wr[i].ctr_we = do_write && hit && (dec.sel == SEL_CTR);
      assign lane_wr[i].part = dec.part;
      assign lane_wr[i].type_we = do_write && hit && (dec.sel == SEL_TYPE);
      assign lane_wr[i].filt_we = do_write && hit && (dec.sel == SEL_FILT);

      fecb_lane #(
         .COUNTER_BITS (COUNTER_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .wr         (lane_wr[i]),
         .wdata      (s1_wdata_ff),
         .cnt_en     (do_event && cen_ff[i]),
         .event_code (s1_code_ff),
         .core_id    (s1_core_ff),
         .intid      (s1_intid_ff),
         .chip_id    (s1_chip_ff),
         .ctr_value  (lane_ctr[i]),
         .type_value (lane_type[i]),
         .filt_value (lane_filt[i]),
         .wrap       (wrap_vec[i])
      );
   end

   always_comb begin
      ctr_sel = '0;
      type_sel = '0;
      filt_sel = '0;
      for (int i = 0; i < CTR_COUNT; i++) begin
         if (dec.idx == IDX_BITS'(i)) begin
            ctr_sel = ctr_sel | lane_ctr[i];
            type_sel = type_sel | lane_type[i];
            filt_sel = filt_sel | lane_filt[i];
         end
      end

      rsp_rdata_in = '0;
      if (s1_func_ff == FUNC_READ) begin
         case (dec.sel)
            SEL_CTR: begin
               case (dec.part)
                  PART_LOW:  rsp_rdata_in = {32'd0, ctr_sel[31:0]};
                  PART_HIGH: rsp_rdata_in = {32'd0, ctr_sel[63:32]};
                  default:   rsp_rdata_in = ctr_sel;
               endcase
            end
            SEL_TYPE:    rsp_rdata_in = 64'(type_sel);
            SEL_FILT:    rsp_rdata_in = 64'(filt_sel);
            SEL_CEN_SET: rsp_rdata_in = 64'(cen_ff);
            SEL_CEN_CLR: rsp_rdata_in = 64'(cen_ff);
            SEL_IEN_SET: rsp_rdata_in = 64'(ien_ff);
            SEL_IEN_CLR: rsp_rdata_in = 64'(ien_ff);
            SEL_OVF:     rsp_rdata_in = 64'(ovf_ff);
            SEL_CFG:     rsp_rdata_in = CFG_WORD;
            SEL_GEN:     rsp_rdata_in = 64'(gen_ff);
            default:     rsp_rdata_in = '0;
         endcase
      end

      cen_in = cen_ff;
      ien_in = ien_ff;
      ovf_in = ovf_ff | wrap_vec;
      gen_in = gen_ff;
      if (do_write) begin
         case (dec.sel)
            SEL_CEN_SET: cen_in = cen_ff | wn;
            SEL_CEN_CLR: cen_in = cen_ff & ~wn;
            SEL_IEN_SET: ien_in = ien_ff | wn;
            SEL_IEN_CLR: ien_in = ien_ff & ~wn;
            SEL_OVF:     ovf_in = ovf_ff & ~wn;
            SEL_GEN:     gen_in = s1_wdata_ff[0];
            default:     gen_in = gen_ff;
         endcase
      end
      rsp_irq_in = |(ovf_in & ien_in);

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cen_ff <= '0;
         ien_ff <= '0;
         ovf_ff <= '0;
         gen_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cen_ff <= cen_in;
         ien_ff <= ien_in;
         ovf_ff <= ovf_in;
         gen_ff <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff <= req_func;
         s1_addr_ff <= req_addr;
         s1_wdata_ff <= req_wdata;
         s1_wide_ff <= req_wide;
         s1_code_ff <= req_event_code;
         s1_core_ff <= req_core_id;
         s1_intid_ff <= req_intid;
         s1_chip_ff <= req_chip_id;
      end
      if (fire) begin
         rsp_rdata_ff <= rsp_rdata_in;
         rsp_irq_ff <= rsp_irq_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rdata = rsp_rdata_ff;
   assign rsp_irq = rsp_irq_ff;

   `FECB_ASSERT_NEXT(a_fire_loads_rsp, fire, rsp_valid, "Item lost before the output.")
   `FECB_ASSERT(a_irq_state, !rsp_valid || (rsp_irq == (|(ovf_ff & ien_ff))), "Stale irq.")
   `FECB_ASSERT(a_no_wrap_when_off, gen_ff || (wrap_vec == '0), "Wrap while counting is off.")
   `FECB_ASSERT_NEXT(a_ovf_wrap, 1'b1, (ovf_ff & ~$past(ovf_ff | wrap_vec)) == '0, "Stray overflow.")

endmodule
